// ===== rtl/scratch_stack_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Scratch stack allocator assertion macros
// Shared assertion forms for the checker of the allocator.
// ----------------------------------------------------------------------------
`ifndef SCRATCH_STACK_ALLOCATOR_MACROS_SVH
`define SCRATCH_STACK_ALLOCATOR_MACROS_SVH

// Checked only while the block is out of reset.
`define SSA_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond) \
        else $error("scratch_stack_allocator check failed");

// Checked at every edge, reset included.
`define SSA_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge i_clk) cond) \
        else $error("scratch_stack_allocator check failed");

`endif

// ===== rtl/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// Scratch stack allocator package
// Request and response beats, decoded commands, codes and sizes.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int ALIGN_W     = 17;

    typedef enum logic [1:0] {
        REQ_TAKE   = 2'd0,
        REQ_MARK   = 2'd1,
        REQ_REWIND = 2'd2,
        REQ_REOPEN = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ARG   = 3'd1,
        ST_NOT_OPEN  = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_ORDER     = 3'd4,
        ST_DEPTH     = 3'd5
    } t_status;

    typedef struct packed {
        t_req_type           req_type;
        logic [31:0]         byte_count;
        logic [ALIGN_W-1:0]  alignment;
        logic [31:0]         mark_offset;
        logic [15:0]         mark_level;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] result_offset;
        logic [15:0] result_level;
        logic [31:0] used_bytes;
        logic [31:0] peak_bytes;
        logic [31:0] exhaustion_total;
    } t_rsp;

    typedef struct packed {
        t_req_type           kind;
        logic                bad_arg;
        logic [ALIGN_W-1:0]  align_mask;
        logic [31:0]         byte_count;
        logic [31:0]         mark_offset;
        logic [15:0]         mark_level;
    } t_cmd;

endpackage

// ===== rtl/ssa_front.sv =====
// ----------------------------------------------------------------------------
// Scratch stack allocator front end
// Decodes a request beat into a command and checks the take arguments.
// ----------------------------------------------------------------------------
module ssa_front
    import ssa_pkg::*;
(
    input  t_req i_req,
    output t_cmd o_cmd
);

    logic [ALIGN_W-1:0] align_m1;

    assign align_m1 = i_req.alignment - ALIGN_W'(1);

    always_comb begin
        o_cmd.kind        = i_req.req_type;
        o_cmd.align_mask  = align_m1;
        o_cmd.byte_count  = i_req.byte_count;
        o_cmd.mark_offset = i_req.mark_offset;
        o_cmd.mark_level  = i_req.mark_level;
        o_cmd.bad_arg     = (i_req.byte_count == 32'd0) ||
                            (i_req.alignment == '0) ||
                            ((i_req.alignment & align_m1) != '0);
    end

endmodule

// ===== rtl/ssa_queue.sv =====
// ----------------------------------------------------------------------------
// Scratch stack allocator command queue
// Small register queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module ssa_queue
    import ssa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/ssa_back.sv =====
// ----------------------------------------------------------------------------
// Scratch stack allocator execution unit
// Applies commands to the allocator state and holds the response register.
// ----------------------------------------------------------------------------
module ssa_back
    import ssa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_capacity,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp
);

    logic        r_valid;
    t_rsp        r_rsp;
    logic [31:0] r_cur;
    logic [31:0] r_peak;
    logic [15:0] r_level;
    logic [31:0] r_exh;
    logic [31:0] n_cur;
    logic [31:0] n_peak;
    logic [15:0] n_level;
    logic [31:0] n_exh;
    t_rsp        n_rsp;
    logic        pop;
    logic [32:0] mask_ext;
    logic [32:0] start;
    logic [33:0] span_end;
    logic        fits;

    assign pop         = i_cmd_valid && (!r_valid || i_rsp_ready);
    assign o_cmd_pop   = pop;
    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

    assign mask_ext = {16'd0, i_cmd.align_mask};
    assign start    = ({1'b0, r_cur} + mask_ext) & ~mask_ext;
    assign span_end = {1'b0, start} + {2'b00, i_cmd.byte_count};
    assign fits     = (span_end <= {2'b00, i_capacity});

    always_comb begin
        n_cur   = r_cur;
        n_peak  = r_peak;
        n_level = r_level;
        n_exh   = r_exh;
        n_rsp.status        = ST_OK;
        n_rsp.result_offset = '0;
        n_rsp.result_level  = '0;
        case (i_cmd.kind)
            REQ_TAKE: begin
                if (i_cmd.bad_arg) begin
                    n_rsp.status = ST_BAD_ARG;
                end else if (i_capacity == '0) begin
                    n_rsp.status = ST_NOT_OPEN;
                end else if (!fits) begin
                    n_rsp.status = ST_EXHAUSTED;
                    if (r_exh != '1) begin
                        n_exh = r_exh + 32'd1;
                    end
                end else begin
                    n_cur               = span_end[31:0];
                    n_rsp.result_offset = start[31:0];
                    if (span_end[31:0] > r_peak) begin
                        n_peak = span_end[31:0];
                    end
                end
            end
            REQ_MARK: begin
                if (r_level == '1) begin
                    n_rsp.status = ST_DEPTH;
                end else begin
                    n_level             = r_level + 16'd1;
                    n_rsp.result_offset = r_cur;
                    n_rsp.result_level  = r_level + 16'd1;
                end
            end
            REQ_REWIND: begin
                if (r_level == '0 || i_cmd.mark_level != r_level) begin
                    n_rsp.status = ST_ORDER;
                end else begin
                    n_cur   = i_cmd.mark_offset;
                    n_level = r_level - 16'd1;
                end
            end
            REQ_REOPEN: begin
                if (i_capacity == '0) begin
                    n_rsp.status = ST_BAD_ARG;
                end else begin
                    n_cur   = '0;
                    n_peak  = '0;
                    n_level = '0;
                    n_exh   = '0;
                end
            end
            default: begin
                n_rsp.status = ST_BAD_ARG;
            end
        endcase
        n_rsp.used_bytes       = n_cur;
        n_rsp.peak_bytes       = n_peak;
        n_rsp.exhaustion_total = n_exh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cur   <= '0;
            r_peak  <= '0;
            r_level <= '0;
            r_exh   <= '0;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                r_cur   <= n_cur;
                r_peak  <= n_peak;
                r_level <= n_level;
                r_exh   <= n_exh;
            end else if (i_rsp_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

// ===== rtl/scratch_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// Scratch stack allocator
// Bump allocator with nested marks, peak tracking and exhaustion counting.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the i_req channel (valid and ready) and each
// produces exactly one response beat on the o_rsp channel, in order.
// The region capacity register sits at byte address 0 of the APB port and
// may only be written while no request is in flight.
// A request that meets an empty queue and an idle response register passes
// the queue entry, then the response register. One request per cycle is
// sustained while the receiver takes each response; the rate is set by
// the offset, peak, level and exhaustion update in the execution unit.
// A two-entry command queue separates the front end from the execution
// unit, so requests are still accepted while a response waits to be taken.
// When the receiver stalls, the response is held and the queue fills; then
// o_req_ready drops until the response is taken.
// Reset clears the capacity, all counters, the queue and the response valid.
// ----------------------------------------------------------------------------
module scratch_stack_allocator
    import ssa_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output t_rsp              o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [31:0] r_capacity;
    t_cmd        front_cmd;
    t_cmd        queue_cmd;
    logic        queue_full;
    logic        queue_valid;
    logic        queue_pop;
    logic        req_push;
    logic        cap_sel;

    assign pready      = 1'b1;
    assign cap_sel     = (paddr[ADDR_W-1:2] == '0);
    assign prdata      = cap_sel ? r_capacity : '0;
    assign o_req_ready = !queue_full;
    assign req_push    = i_req_valid && !queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_capacity <= pwdata;
        end
    end

    ssa_front u_front (
        .i_req (i_req),
        .o_cmd (front_cmd)
    );

    ssa_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    ssa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== rtl/ssa_checker.sv =====
// ----------------------------------------------------------------------------
// Scratch stack allocator checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "scratch_stack_allocator_macros.svh"

module ssa_checker
    import ssa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    `SSA_ASSERT_ALWAYS(a_no_rsp_after_reset, !i_rst_n |=> !o_rsp_valid)
    `SSA_ASSERT(a_rsp_held, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
    `SSA_ASSERT(a_fail_no_result, o_rsp_valid && o_rsp.status != ST_OK |-> o_rsp.result_offset == '0 && o_rsp.result_level == '0)
    `SSA_ASSERT(a_status_known, o_rsp_valid |-> o_rsp.status <= ST_DEPTH)
    `SSA_ASSERT(a_mark_level, o_rsp_valid && o_rsp.status == ST_OK && o_rsp.result_level != '0 |-> o_rsp.result_offset == o_rsp.used_bytes)

endmodule

bind scratch_stack_allocator ssa_checker u_ssa_checker (.*);

// ===== tb/scratch_stack_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scratch stack allocator testbench
// Drives take, mark, rewind and reopen beats through the request channel,
// predicts every response from its own model of the offset, peak, nesting
// level and exhaustion count, and checks each response beat field by field.
// Runs over several region capacities, with random sender bursts, receiver
// stalls and long receiver hold-offs.
// ----------------------------------------------------------------------------
module scratch_stack_allocator_tb;
    import ssa_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 80;
    localparam int PHASE_ITEMS    = 215;
    localparam logic [ADDR_W-1:0] REG_REGION_CAPACITY = '0;

    typedef struct packed {
        logic [31:0] capacity;
        logic [31:0] offset;
        logic [31:0] peak;
        logic [15:0] level;
        logic [31:0] exhausts;
    } t_alloc_state;

    typedef struct packed {
        logic [31:0] offset;
        logic [15:0] level;
    } t_saved_mark;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_req_valid = 1'b0;
    logic              o_req_ready;
    t_req              i_req       = '0;
    logic              o_rsp_valid;
    logic              i_rsp_ready = 1'b0;
    t_rsp              o_rsp;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_alloc_state plan_state = '0;
    t_alloc_state live_state = '0;
    t_saved_mark  mark_stack[$];
    t_req         pending_reqs[$];
    t_rsp         alloc_reports_due[$];

    int planned_total  = 0;
    int req_beats      = 0;
    int rsp_beats      = 0;
    int failures       = 0;
    int cap_settings   = 0;
    int idle_cycles    = 0;
    int stall_asked    = 0;
    int stall_done     = 0;
    int status_seen[8] = '{default: 0};
    bit req_beat_taken = 1'b0;

    scratch_stack_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_rsp alloc_step(inout t_alloc_state s, input t_req r);
        t_rsp        rsp;
        logic [32:0] amask;
        logic [32:0] start;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.req_type)
            REQ_TAKE: begin
                amask = {16'd0, r.alignment} - 33'd1;
                if (r.byte_count == '0 || r.alignment == '0
                        || (r.alignment & (r.alignment - 1'b1)) != '0) begin
                    rsp.status = ST_BAD_ARG;
                end else if (s.capacity == '0) begin
                    rsp.status = ST_NOT_OPEN;
                end else begin
                    start = ({1'b0, s.offset} + amask) & ~amask;
                    if (start > {1'b0, s.capacity}
                            || {1'b0, r.byte_count} > {1'b0, s.capacity} - start) begin
                        if (s.exhausts != '1) s.exhausts = s.exhausts + 32'd1;
                        rsp.status = ST_EXHAUSTED;
                    end else begin
                        s.offset = start[31:0] + r.byte_count;
                        if (s.offset > s.peak) s.peak = s.offset;
                        rsp.result_offset = start[31:0];
                    end
                end
            end
            REQ_MARK: begin
                if (s.level == '1) begin
                    rsp.status = ST_DEPTH;
                end else begin
                    s.level = s.level + 16'd1;
                    rsp.result_offset = s.offset;
                    rsp.result_level = s.level;
                end
            end
            REQ_REWIND: begin
                if (s.level == '0 || r.mark_level != s.level) begin
                    rsp.status = ST_ORDER;
                end else begin
                    s.offset = r.mark_offset;
                    s.level = s.level - 16'd1;
                end
            end
            default: begin
                if (s.capacity == '0) begin
                    rsp.status = ST_BAD_ARG;
                end else begin
                    s.offset = '0;
                    s.peak = '0;
                    s.level = '0;
                    s.exhausts = '0;
                end
            end
        endcase
        rsp.used_bytes = s.offset;
        rsp.peak_bytes = s.peak;
        rsp.exhaustion_total = s.exhausts;
        return rsp;
    endfunction

    function automatic t_req mk(input t_req_type kind, input logic [31:0] count,
                                input logic [ALIGN_W-1:0] align, input logic [31:0] moff,
                                input logic [15:0] mlev);
        t_req r;
        r.req_type = kind;
        r.byte_count = count;
        r.alignment = align;
        r.mark_offset = moff;
        r.mark_level = mlev;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req        r;
        int unsigned pick;
        logic [63:0] span;
        r = mk(REQ_TAKE, $urandom, ALIGN_W'($urandom), $urandom, 16'($urandom));
        pick = $urandom_range(0, 99);
        span = 64'(plan_state.capacity >> 4) + 64'd1;
        if (pick < 48) begin
            case ($urandom_range(0, 9))
                0: r.byte_count = '0;
                1: ;
                default: r.byte_count = 32'(64'd1 + 64'($urandom) % span);
            endcase
            case ($urandom_range(0, 9))
                0: r.alignment = '0;
                1: ;
                2, 3, 4, 5, 6: r.alignment = ALIGN_W'(1) << $urandom_range(0, 4);
                default: r.alignment = ALIGN_W'(1) << $urandom_range(0, 16);
            endcase
        end else if (pick < 68) begin
            r.req_type = REQ_MARK;
        end else if (pick < 92) begin
            r.req_type = REQ_REWIND;
            if (mark_stack.size() > 0 && $urandom_range(0, 9) < 7) begin
                r.mark_offset = mark_stack[$].offset;
                r.mark_level = mark_stack[$].level;
            end else if ($urandom_range(0, 1) == 0) begin
                r.mark_level = plan_state.level;
            end
        end else begin
            r.req_type = REQ_REOPEN;
        end
        return r;
    endfunction

    task automatic plan(input t_req r);
        t_rsp outcome;
        outcome = alloc_step(plan_state, r);
        if (r.req_type == REQ_MARK && outcome.status == ST_OK)
            mark_stack.push_back({outcome.result_offset, outcome.result_level});
        while (mark_stack.size() > 0 && mark_stack[$].level > plan_state.level)
            void'(mark_stack.pop_back());
        pending_reqs.push_back(r);
        planned_total++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (rsp_beats < planned_total);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        logic [31:0] rd;
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = REG_REGION_CAPACITY;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (rd !== value) begin
            $display("%0t ns: region_capacity readback mismatch, expected %h, got %h",
                     $time, value, rd);
            failures++;
        end
        plan_state.capacity = value;
        live_state.capacity = value;
        cap_settings++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            failures++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        static int burst_left = 1;
        static int gap_left   = 0;
        logic      nxt_valid;
        t_req      nxt_req;
        nxt_valid = i_req_valid;
        nxt_req = i_req;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_req_valid || req_beat_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                nxt_req = pending_reqs.pop_front();
                nxt_valid = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
        i_req_valid <= nxt_valid;
        i_req <= nxt_req;
    end

    // Receiver: a stall pattern that switches mode now and then.
    always @(negedge i_clk) begin
        static int rx_mode    = 0;
        static int mode_left  = 0;
        static int stall_left = 0;
        static int rx_tick    = 0;
        logic      nxt_ready;
        rx_tick++;
        if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
        end else if (stall_asked != stall_done) begin
            stall_done++;
            stall_left = LONG_STALL;
            nxt_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (rx_mode)
                0: nxt_ready = 1'b1;
                1: nxt_ready = 1'($urandom_range(0, 1));
                2: nxt_ready = ($urandom_range(0, 3) == 0);
                default: nxt_ready = (rx_tick % 5 < 3);
            endcase
        end
        i_rsp_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        req_beat_taken = 1'b0;
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_beats++;
                if (alloc_reports_due.size() == 0) begin
                    $display("%0t ns: response beat with none expected, got %h", $time, o_rsp);
                    failures++;
                end else begin
                    want = alloc_reports_due.pop_front();
                    status_seen[want.status]++;
                    check_field("status", 32'(want.status), 32'(o_rsp.status));
                    check_field("result_offset", want.result_offset, o_rsp.result_offset);
                    check_field("result_level", 32'(want.result_level),
                                32'(o_rsp.result_level));
                    check_field("used_bytes", want.used_bytes, o_rsp.used_bytes);
                    check_field("peak_bytes", want.peak_bytes, o_rsp.peak_bytes);
                    check_field("exhaustion_total", want.exhaustion_total,
                                o_rsp.exhaustion_total);
                end
            end
            if (i_req_valid && o_req_ready) begin
                alloc_reports_due.push_back(alloc_step(live_state, i_req));
                req_beats++;
                req_beat_taken = 1'b1;
            end
            if (req_beat_taken || (o_rsp_valid && i_rsp_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] phase_caps[$];
        int          start_beats;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        plan(mk(REQ_TAKE, 32'd8, 17'd4, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd0, 17'd4, 32'd0, 16'd0));
        plan(mk(REQ_REOPEN, 32'd0, 17'd0, 32'd0, 16'd0));
        plan(mk(REQ_MARK, 32'd0, 17'd0, 32'd0, 16'd0));
        plan(mk(REQ_REWIND, 32'd0, 17'd0, 32'd0, 16'd1));
        wait_drained();
        write_capacity(32'd100);

        plan(mk(REQ_TAKE, 32'd1, 17'd1, '1, '1));
        plan(mk(REQ_TAKE, 32'd10, 17'd8, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd1, 17'h10000, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd1, 17'd3, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd1, 17'd0, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd0, 17'd4, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, '1, 17'd1, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd82, 17'd1, 32'd0, 16'd0));
        plan(mk(REQ_TAKE, 32'd1, 17'd1, 32'd0, 16'd0));
        plan(mk(REQ_MARK, '1, '1, '1, '1));
        plan(mk(REQ_REWIND, 32'd0, 17'd0, 32'd0, 16'd2));
        plan(mk(REQ_REWIND, 32'd0, 17'd0, '1, 16'd1));
        plan(mk(REQ_TAKE, 32'd1, 17'd1, 32'd0, 16'd0));
        plan(mk(REQ_REWIND, 32'd0, 17'd0, 32'd0, 16'd0));
        plan(mk(REQ_MARK, 32'd0, 17'd0, 32'd0, 16'd0));
        plan(mk(REQ_MARK, 32'd0, 17'd0, 32'd0, 16'd0));
        plan(mk(REQ_REWIND, 32'd0, 17'd0, 32'd20, 16'd2));
        plan(mk(REQ_REWIND, 32'd0, 17'd0, 32'd4, 16'd1));
        plan(mk(REQ_REOPEN, '1, '1, '1, '1));
        plan(mk(REQ_TAKE, 32'd100, 17'd4096, 32'd0, 16'd0));
        wait_drained();

        phase_caps = '{32'd4096, 32'd0, 32'd1, 32'd300, $urandom, '1, 32'd65536};
        foreach (phase_caps[ph]) begin
            write_capacity(phase_caps[ph]);
            start_beats = req_beats;
            repeat (PHASE_ITEMS) plan(random_req());
            if (ph == 2 || ph == 5) begin
                wait (req_beats >= start_beats + 50);
                stall_asked++;
            end
            wait_drained();
        end
        repeat (8) @(negedge i_clk);

        $display("Summary: %0d request beats, %0d response beats, %0d capacity settings.",
                 req_beats, rsp_beats, cap_settings);
        $display("Statuses seen: ok %0d, bad arg %0d, not open %0d, exhausted %0d,",
                 status_seen[ST_OK], status_seen[ST_BAD_ARG], status_seen[ST_NOT_OPEN],
                 status_seen[ST_EXHAUSTED]);
        $display("  order %0d, depth %0d.", status_seen[ST_ORDER], status_seen[ST_DEPTH]);
        if (failures == 0 && alloc_reports_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
